[rtl/bce_pkg.sv]
// Shared types, constants and helpers of the binary contour extractor.
package bce_pkg;

   // Default size limits of the frame
   localparam int unsigned DEF_MAX_WIDTH  = 1024;
   localparam int unsigned DEF_MAX_HEIGHT = 4096;

   // Field widths
   localparam int unsigned WIDTH_REG_W  = 11;
   localparam int unsigned HEIGHT_REG_W = 13;
   localparam int unsigned THRESH_W     = 8;
   localparam int unsigned CHAN_W       = 8;
   localparam int unsigned LEVEL_W      = 8;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 13;

   // Register reset values
   localparam int unsigned                RESET_WIDTH     = 640;
   localparam int unsigned                RESET_HEIGHT    = 480;
   localparam logic [THRESH_W-1:0]        RESET_THRESHOLD = 8'd220;

   // Output levels
   localparam logic [LEVEL_W-1:0] LEVEL_WHITE = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_BLACK = 8'd0;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_WHITE_THRESHOLD = 2'd2
   } csr_index_type;

   // Request kinds
   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_DRAIN = 1'b1
   } item_kind_type;

   // Ring word at slot a: {bit a-2, bit a-1, bit a}
   typedef logic [2:0] triple_type;

   // Lookup issued by the front end, carried through the read stage
   typedef struct packed {
      logic       check_en;    // interior pixel with a complete neighborhood
      logic       last;        // final pixel of the frame
      logic       fwd_upper;   // read slot equals the slot written in the same cycle
      logic       fwd_middle;
      logic       fwd_lower;
      logic       fwd_center;
      triple_type fwd_word;    // word written in that cycle
   } issue_type;

   // Frame size as used: zero acts as one, the top is capped at the limit
   function automatic int unsigned clamp_size(int unsigned raw, int unsigned max_size);
      int unsigned res;
      if (raw == 0) begin
         res = 1;
      end else if (raw > max_size) begin
         res = max_size;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

[rtl/bce_ifs.sv]
// Channel interfaces of the binary contour extractor: request, response, register write.

interface bce_req_if
   import bce_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, kind, red, green, blue, input ready);
   modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface bce_rsp_if
   import bce_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] pixel_level;
   logic               last_of_frame;

   modport source (output valid, pixel_level, last_of_frame, input ready);
   modport sink   (input valid, pixel_level, last_of_frame, output ready);
endinterface

interface bce_csr_if
   import bce_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/binary_contour_extract_unit.sv]
// Top level of the binary contour extractor: front end, two pixel rings, back end.
//
//  channel   direction  handshake        payload
//  req_bus   in         valid / ready    kind, red, green, blue
//  rsp_bus   out        valid / ready    pixel_level, last_of_frame
//  csr_bus   in         valid / ready    index, data (always ready)
//
// One request per clock unless stalled; responses pass the read stage and response
// register, and a pixel's response is caused by the request width+1 requests later.
// The rate is set by the ring lookup: four slots read per request over two
// dual-read copies of the ring, with same-cycle writes forwarded.
// Reset clears all control state; ring contents are unknown until written.
// A stalled response holds in its register while one more lookup waits behind it.
module binary_contour_extract_unit
   import bce_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   bce_req_if.sink    req_bus,
   bce_rsp_if.source  rsp_bus,
   bce_csr_if.sink    csr_bus
);

   localparam int unsigned RING_AW = $clog2(MAX_WIDTH) + 2;

   logic               issue_valid;
   logic               issue_ready;
   issue_type          issue;
   logic               wr_en;
   logic [RING_AW-1:0] wr_addr;
   triple_type         wr_word;
   logic [RING_AW-1:0] rd_addr_upper;
   logic [RING_AW-1:0] rd_addr_middle;
   logic [RING_AW-1:0] rd_addr_lower;
   logic [RING_AW-1:0] rd_addr_center;
   triple_type         rd_upper;
   triple_type         rd_middle;
   triple_type         rd_lower;
   triple_type         rd_center;

   bce_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .csr            (csr_bus),
      .issue_ready    (issue_ready),
      .issue_valid    (issue_valid),
      .issue          (issue),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_word        (wr_word),
      .rd_addr_upper  (rd_addr_upper),
      .rd_addr_middle (rd_addr_middle),
      .rd_addr_lower  (rd_addr_lower),
      .rd_addr_center (rd_addr_center)
   );

   // Upper and middle rows
   bce_ring_mem #(
      .ADDR_W (RING_AW)
   ) u_ring_a (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_word),
      .rd_en     (issue_valid),
      .rd_addr_a (rd_addr_upper),
      .rd_addr_b (rd_addr_middle),
      .rd_data_a (rd_upper),
      .rd_data_b (rd_middle)
   );

   // Lower row and center pixel
   bce_ring_mem #(
      .ADDR_W (RING_AW)
   ) u_ring_b (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_word),
      .rd_en     (issue_valid),
      .rd_addr_a (rd_addr_lower),
      .rd_addr_b (rd_addr_center),
      .rd_data_a (rd_lower),
      .rd_data_b (rd_center)
   );

   bce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue       (issue),
      .issue_ready (issue_ready),
      .rd_upper    (rd_upper),
      .rd_middle   (rd_middle),
      .rd_lower    (rd_lower),
      .rd_center   (rd_center),
      .rsp         (rsp_bus)
   );

endmodule

[rtl/bce_ring_mem.sv]
// Ring of binary pixel triples: one write port, two registered read ports.
module bce_ring_mem
   import bce_pkg::*;
#(
   parameter int unsigned ADDR_W = $clog2(DEF_MAX_WIDTH) + 2
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  triple_type        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output triple_type        rd_data_a,
   output triple_type        rd_data_b
);

   triple_type ring_ff [2**ADDR_W];
   triple_type rd_a_ff;
   triple_type rd_b_ff;

   // Write, then read with old data on a same-slot collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= ring_ff[rd_addr_a];
         rd_b_ff <= ring_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/bce_front.sv]
// Front end: registers, binarization, ring pointers, frame position and lookup issue.
module bce_front
   import bce_pkg::*;
#(
   parameter  int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter  int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int unsigned RING_AW    = $clog2(MAX_WIDTH) + 2
) (
   input  logic               clock,
   input  logic               reset,
   bce_req_if.sink            req,
   bce_csr_if.sink            csr,
   input  logic               issue_ready,
   output logic               issue_valid,
   output issue_type          issue,
   output logic               wr_en,
   output logic [RING_AW-1:0] wr_addr,
   output triple_type         wr_word,
   output logic [RING_AW-1:0] rd_addr_upper,
   output logic [RING_AW-1:0] rd_addr_middle,
   output logic [RING_AW-1:0] rd_addr_lower,
   output logic [RING_AW-1:0] rd_addr_center
);

   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned RW = $clog2(MAX_HEIGHT);
   localparam int unsigned PW = $clog2(MAX_WIDTH + 2);
   localparam logic [WW-1:0] RST_WIDTH  = WW'(clamp_size(RESET_WIDTH, MAX_WIDTH));
   localparam logic [HW-1:0] RST_HEIGHT = HW'(clamp_size(RESET_HEIGHT, MAX_HEIGHT));

   logic [WW-1:0]       width_ff;
   logic [HW-1:0]       height_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [PW-1:0]       pending_ff, pending_in;
   logic [RING_AW-1:0]  wr_ptr_ff;
   logic [RING_AW-1:0]  tail_ff;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic                prev1_ff;
   logic                prev2_ff;

   logic               accept;
   logic               is_pixel;
   logic               white;
   logic               emit;
   logic               full_window;
   logic               border;
   logic               last;
   logic [CW-1:0]      width_m1;
   logic [PW-1:0]      width_p1;
   logic [RW-1:0]      height_m1;
   logic [RING_AW-1:0] width_a;
   logic [RING_AW-1:0] tail_p1;

   assign req.ready = issue_ready;
   assign csr.ready = 1'b1;

   // Decode of the request and the emit decision
   always_comb begin
      accept      = req.valid && req.ready;
      is_pixel    = req.kind != KIND_DRAIN;
      white       = (req.red >= thresh_ff) && (req.green >= thresh_ff) &&
                    (req.blue >= thresh_ff);
      width_m1    = CW'(width_ff - 1'b1);
      width_p1    = PW'(width_ff) + PW'(1);
      height_m1   = RW'(height_ff - 1'b1);
      // a pixel emits once width+1 or more pixels wait; a drain whenever any waits
      emit        = is_pixel ? (pending_ff >= width_p1) : (pending_ff != '0);
      full_window = is_pixel || (pending_ff > width_p1);
      border      = (row_ff == '0) || (col_ff == '0) ||
                    (row_ff >= height_m1) || (col_ff >= width_m1);
      last        = (row_ff >= height_m1) && (col_ff >= width_m1);
   end

   // Next pending count and frame position
   always_comb begin
      pending_in = pending_ff;
      if (is_pixel && !emit) begin
         pending_in = pending_ff + PW'(1);
      end else if (!is_pixel && emit) begin
         pending_in = pending_ff - PW'(1);
      end
      col_in = col_ff + CW'(1);
      row_in = row_ff;
      if (col_ff >= width_m1) begin
         col_in = '0;
         row_in = (row_ff >= height_m1) ? '0 : row_ff + RW'(1);
      end
   end

   // Ring write and the four lookup slots around the center pixel
   always_comb begin
      width_a        = RING_AW'(width_ff);
      tail_p1        = tail_ff + RING_AW'(1);
      wr_en          = accept && is_pixel;
      wr_addr        = wr_ptr_ff;
      wr_word        = {prev2_ff, prev1_ff, white};
      rd_addr_upper  = tail_p1 - width_a;
      rd_addr_middle = tail_p1;
      rd_addr_lower  = tail_p1 + width_a;
      rd_addr_center = tail_ff;

      issue_valid       = accept && emit;
      issue.check_en    = full_window && !border;
      issue.last        = last;
      issue.fwd_upper   = is_pixel && (rd_addr_upper == wr_ptr_ff);
      issue.fwd_middle  = is_pixel && (rd_addr_middle == wr_ptr_ff);
      issue.fwd_lower   = is_pixel && (rd_addr_lower == wr_ptr_ff);
      issue.fwd_center  = is_pixel && (rd_addr_center == wr_ptr_ff);
      issue.fwd_word    = wr_word;
   end

   // Registers, pointers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_WIDTH;
         height_ff  <= RST_HEIGHT;
         thresh_ff  <= RESET_THRESHOLD;
         pending_ff <= '0;
         wr_ptr_ff  <= '0;
         tail_ff    <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         prev1_ff   <= 1'b0;
         prev2_ff   <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            unique case (csr_index_type'(csr.index))
               CSR_IMAGE_WIDTH: begin
                  width_ff <= WW'(clamp_size(32'(csr.data[WIDTH_REG_W-1:0]), MAX_WIDTH));
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= HW'(clamp_size(32'(csr.data[HEIGHT_REG_W-1:0]), MAX_HEIGHT));
               end
               CSR_WHITE_THRESHOLD: begin
                  thresh_ff <= csr.data[THRESH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            pending_ff <= pending_in;
            if (is_pixel) begin
               wr_ptr_ff <= wr_ptr_ff + RING_AW'(1);
               prev2_ff  <= prev1_ff;
               prev1_ff  <= white;
            end
            if (emit) begin
               tail_ff <= tail_p1;
               col_ff  <= col_in;
               row_ff  <= row_in;
            end
         end
      end
   end

   // Pending never outgrows one row plus one pixel at the largest width
   assert property (@(posedge clock) disable iff (reset)
      32'(pending_ff) <= MAX_WIDTH + 1)
      else $error("pending count beyond ring lookback");

   // Write and center pointers stay the pending count apart
   assert property (@(posedge clock) disable iff (reset)
      RING_AW'(wr_ptr_ff - tail_ff) == RING_AW'(pending_ff))
      else $error("ring pointers out of step with pending count");

   // A pixel that emits leaves the pending count unchanged
   assert property (@(posedge clock) disable iff (reset)
      accept && is_pixel && emit |=> pending_ff == $past(pending_ff))
      else $error("emitting pixel changed pending count");

endmodule

[rtl/bce_back.sv]
// Back end: read stage, 3x3 interior test and response register.
module bce_back
   import bce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       issue_valid,
   input  issue_type  issue,
   output logic       issue_ready,
   input  triple_type rd_upper,
   input  triple_type rd_middle,
   input  triple_type rd_lower,
   input  triple_type rd_center,
   bce_rsp_if.source  rsp
);

   logic      s1_valid_ff;
   issue_type s1_ff;
   logic      out_valid_ff;
   logic      out_white_ff;
   logic      out_last_ff;

   logic       s1_move;
   triple_type upper;
   triple_type middle;
   triple_type lower;
   triple_type center;
   logic       all_white;
   logic       result_white;

   // Stage hand-off: the read stage moves when the response slot frees
   always_comb begin
      s1_move     = s1_valid_ff && (!out_valid_ff || rsp.ready);
      issue_ready = !s1_valid_ff || s1_move;
   end

   // Forward a same-cycle ring write, then test the neighborhood
   always_comb begin
      upper        = s1_ff.fwd_upper  ? s1_ff.fwd_word : rd_upper;
      middle       = s1_ff.fwd_middle ? s1_ff.fwd_word : rd_middle;
      lower        = s1_ff.fwd_lower  ? s1_ff.fwd_word : rd_lower;
      center       = s1_ff.fwd_center ? s1_ff.fwd_word : rd_center;
      all_white    = &{upper, middle, lower};
      result_white = center[0] && !(s1_ff.check_en && all_white);
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pixel_level   = out_white_ff ? LEVEL_WHITE : LEVEL_BLACK;
   assign rsp.last_of_frame = out_last_ff;

   // Read stage and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (issue_ready) begin
            s1_valid_ff <= issue_valid;
         end
         if (issue_valid && issue_ready) begin
            s1_ff <= issue;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
            out_white_ff <= result_white;
            out_last_ff  <= s1_ff.last;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // The front end only issues into a free read stage
   assert property (@(posedge clock) disable iff (reset)
      issue_valid |-> issue_ready)
      else $error("lookup issued while read stage is blocked");

   // An issued lookup occupies the read stage in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      issue_valid && issue_ready |=> s1_valid_ff)
      else $error("issued lookup lost");

endmodule
